// ----- design/lz10_pkg.sv -----
// Shared types and constants for the LZ10 block decompressor.
// Used by lz10_block_decompressor; no dependencies.

package lz10_pkg;

    // Default size of one decompressed block in bytes
    localparam int LZ10_OUT_SIZE = 128;

    // Stream type byte of an LZ10 payload
    localparam logic [7:0] LZ10_TYPE = 8'h10;

    // Bias added to the length nibble of a back reference
    localparam logic [4:0] LZ10_LEN_BIAS = 5'd3;

    // Width of the index field of a result word
    localparam int LZ10_IDX_W = 7;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes reported in the final word
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_TYPE = 3'd1,
        ST_BAD_SIZE = 3'd2,
        ST_BAD_REF  = 3'd3,
        ST_OVERRUN  = 3'd4,
        ST_TRUNC    = 3'd5
    } status_t;

    // Parse position within the compressed stream
    typedef enum logic [2:0] {
        PH_TYPE  = 3'd0,
        PH_SIZE0 = 3'd1,
        PH_SIZE1 = 3'd2,
        PH_SIZE2 = 3'd3,
        PH_FLAG  = 3'd4,
        PH_ITEM  = 3'd5,
        PH_REF2  = 3'd6,
        PH_DRAIN = 3'd7
    } phase_t;

    // Sequencer states
    typedef enum logic [2:0] {
        SQ_IN   = 3'd0,
        SQ_DEC  = 3'd1,
        SQ_RD   = 3'd2,
        SQ_WR   = 3'd3,
        SQ_STAT = 3'd4
    } seq_t;

endpackage

// ----- design/lz10_block_decompressor.sv -----
// LZ10 block decompressor: top level, parse sequencer and copy engine.
// Depends on lz10_pkg and lz10_ram (history buffer).
//
// Usage:
//   The in channel (in_valid/in_ready) takes the compressed payload one word
//   at a time: in_byte plus in_last on the final word. The out channel
//   (out_valid/out_ready) delivers one word per decompressed byte (kind 0,
//   out_index, out_byte) and, after the word marked in_last, one status word
//   (kind 1, status, out_last 1).
//   One input word is handled at a time; in_ready is low while it is worked.
//   Each word is accepted (SQ_IN) and then decoded (SQ_DEC). The second word of
//   a back reference goes on to copy up to 18 bytes, each a history RAM read (SQ_RD)
//   followed by a write of the same RAM (SQ_WR), with one copy address counter
//   shared by all bytes. The status word follows the word marked last.
//   One output register separates the two sides; when the receiver stalls,
//   the sequencer waits with the next result and the input stays blocked.
//   Reset returns the parser to expect a type word and empties the output
//   register. The history RAM is not cleared; a reference only reads bytes
//   produced earlier in the same block.

module lz10_block_decompressor
    import lz10_pkg::*;
#(
    parameter int OUT_SIZE = LZ10_OUT_SIZE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  kind,
    output logic [LZ10_IDX_W-1:0] out_index,
    output logic [7:0]            out_byte,
    output logic [2:0]            status,
    output logic                  out_last
);

    localparam int CW   = $clog2(OUT_SIZE + 1);
    localparam int AW   = $clog2(OUT_SIZE);
    localparam int CMPW = ((CW > 13) ? CW : 13) + 1;

    // Sequencer and parser state
    seq_t            seq_reg, seq_next;
    phase_t          phase_reg, phase_next;
    status_t         error_reg, error_next;
    logic [15:0]     size_acc_reg, size_acc_next;
    logic [7:0]      flag_bits_reg, flag_bits_next;
    logic [3:0]      flag_pos_reg, flag_pos_next;
    logic [7:0]      ref_first_reg, ref_first_next;
    logic [CW-1:0]   out_count_reg, out_count_next;
    logic [AW-1:0]   src_reg, src_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [7:0]      byte_in_reg, byte_in_next;
    logic            last_in_reg, last_in_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic                  kind_reg;
    logic [LZ10_IDX_W-1:0] index_reg;
    logic [7:0]            obyte_reg;
    status_t               status_reg;
    logic                  olast_reg;

    // Result load controls
    logic                  load;
    logic                  ld_kind;
    logic [LZ10_IDX_W-1:0] ld_index;
    logic [7:0]            ld_byte;
    status_t               ld_status;
    logic                  ld_last;

    // History RAM controls
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [7:0]    mem_rdata;

    // Decode helpers
    logic            in_fire;
    logic            slot_free;
    logic            start_copy;
    logic [CW-1:0]   item_count;
    logic [3:0]      pos_dec;
    phase_t          item_phase;
    logic [4:0]      ref_len;
    logic [CMPW-1:0] ref_dist;
    logic [CMPW-1:0] count_w;
    logic [CMPW-1:0] src_w;

    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Next-item bookkeeping shared by literals and copied bytes
    assign item_count = out_count_reg + CW'(1);
    assign pos_dec    = (flag_pos_reg != 4'd0) ? (flag_pos_reg - 4'd1) : 4'd0;

    always_comb
    begin
        if (item_count >= CW'(OUT_SIZE))
        begin
            item_phase = PH_DRAIN;
        end
        else if (pos_dec == 4'd0)
        begin
            item_phase = PH_FLAG;
        end
        else
        begin
            item_phase = PH_ITEM;
        end
    end

    // Back reference fields
    assign ref_len  = {1'b0, ref_first_reg[7:4]} + LZ10_LEN_BIAS;
    assign ref_dist = CMPW'({ref_first_reg[3:0], byte_in_reg}) + CMPW'(1);
    assign count_w  = CMPW'(out_count_reg);
    assign src_w    = count_w - ref_dist;

    // Datapath and result controls
    always_comb
    begin
        phase_next     = phase_reg;
        error_next     = error_reg;
        size_acc_next  = size_acc_reg;
        flag_bits_next = flag_bits_reg;
        flag_pos_next  = flag_pos_reg;
        ref_first_next = ref_first_reg;
        out_count_next = out_count_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        byte_in_next   = byte_in_reg;
        last_in_next   = last_in_reg;
        start_copy     = 1'b0;
        load           = 1'b0;
        ld_kind        = KIND_DATA;
        ld_index       = LZ10_IDX_W'(out_count_reg);
        ld_byte        = byte_in_reg;
        ld_status      = ST_OK;
        ld_last        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = out_count_reg[AW-1:0];
        mem_wdata      = byte_in_reg;
        mem_re         = 1'b0;

        case (seq_reg)
            SQ_IN:
            begin
                if (in_fire)
                begin
                    byte_in_next = in_byte;
                    last_in_next = in_last;
                end
            end
            SQ_DEC:
            begin
                if (slot_free)
                begin
                    case (phase_reg)
                        PH_TYPE:
                        begin
                            if (byte_in_reg != LZ10_TYPE)
                            begin
                                error_next = ST_BAD_TYPE;
                                phase_next = PH_DRAIN;
                            end
                            else
                            begin
                                phase_next = PH_SIZE0;
                            end
                        end
                        PH_SIZE0:
                        begin
                            size_acc_next = {8'h00, byte_in_reg};
                            phase_next    = PH_SIZE1;
                        end
                        PH_SIZE1:
                        begin
                            size_acc_next = {byte_in_reg, size_acc_reg[7:0]};
                            phase_next    = PH_SIZE2;
                        end
                        PH_SIZE2:
                        begin
                            if ({byte_in_reg, size_acc_reg} != 24'(OUT_SIZE))
                            begin
                                error_next = ST_BAD_SIZE;
                                phase_next = PH_DRAIN;
                            end
                            else
                            begin
                                phase_next = PH_FLAG;
                            end
                        end
                        PH_FLAG:
                        begin
                            flag_bits_next = byte_in_reg;
                            flag_pos_next  = 4'd8;
                            phase_next     = PH_ITEM;
                        end
                        PH_ITEM:
                        begin
                            if (flag_bits_reg[7])
                            begin
                                ref_first_next = byte_in_reg;
                                phase_next     = PH_REF2;
                            end
                            else
                            begin
                                // Emit the literal and record it in history
                                mem_we         = 1'b1;
                                load           = 1'b1;
                                out_count_next = item_count;
                                flag_bits_next = {flag_bits_reg[6:0], 1'b0};
                                flag_pos_next  = pos_dec;
                                phase_next     = item_phase;
                            end
                        end
                        PH_REF2:
                        begin
                            if (ref_dist > count_w)
                            begin
                                error_next = ST_BAD_REF;
                                phase_next = PH_DRAIN;
                            end
                            else if (count_w + CMPW'(ref_len) > CMPW'(OUT_SIZE))
                            begin
                                error_next = ST_OVERRUN;
                                phase_next = PH_DRAIN;
                            end
                            else
                            begin
                                start_copy = 1'b1;
                                src_next   = src_w[AW-1:0];
                                cnt_next   = ref_len;
                            end
                        end
                        PH_DRAIN:
                        begin
                            // Ignore trailing words
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            SQ_RD:
            begin
                mem_re = 1'b1;
            end
            SQ_WR:
            begin
                mem_wdata = mem_rdata;
                ld_byte   = mem_rdata;
                if (slot_free)
                begin
                    // Emit one copied byte and advance the copy pointer
                    mem_we         = 1'b1;
                    load           = 1'b1;
                    out_count_next = item_count;
                    src_next       = src_reg + AW'(1);
                    cnt_next       = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        flag_bits_next = {flag_bits_reg[6:0], 1'b0};
                        flag_pos_next  = pos_dec;
                        phase_next     = item_phase;
                    end
                end
            end
            SQ_STAT:
            begin
                ld_kind  = KIND_STATUS;
                ld_index = '0;
                ld_byte  = 8'h00;
                ld_last  = 1'b1;
                if (error_reg == ST_OK &&
                    !(phase_reg == PH_DRAIN && out_count_reg >= CW'(OUT_SIZE)))
                begin
                    ld_status = ST_TRUNC;
                end
                else
                begin
                    ld_status = error_reg;
                end
                if (slot_free)
                begin
                    // Emit the status word and restart the stream
                    load           = 1'b1;
                    phase_next     = PH_TYPE;
                    error_next     = ST_OK;
                    size_acc_next  = '0;
                    flag_bits_next = '0;
                    flag_pos_next  = '0;
                    ref_first_next = '0;
                    out_count_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SQ_IN:
            begin
                if (in_fire)
                begin
                    seq_next = SQ_DEC;
                end
            end
            SQ_DEC:
            begin
                if (slot_free)
                begin
                    if (start_copy)
                    begin
                        seq_next = SQ_RD;
                    end
                    else if (last_in_reg)
                    begin
                        seq_next = SQ_STAT;
                    end
                    else
                    begin
                        seq_next = SQ_IN;
                    end
                end
            end
            SQ_RD:
            begin
                seq_next = SQ_WR;
            end
            SQ_WR:
            begin
                if (slot_free)
                begin
                    if (cnt_reg != 5'd1)
                    begin
                        seq_next = SQ_RD;
                    end
                    else if (last_in_reg)
                    begin
                        seq_next = SQ_STAT;
                    end
                    else
                    begin
                        seq_next = SQ_IN;
                    end
                end
            end
            SQ_STAT:
            begin
                if (slot_free)
                begin
                    seq_next = SQ_IN;
                end
            end
            default:
            begin
                seq_next = SQ_IN;
            end
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_IN;
            phase_reg     <= PH_TYPE;
            error_reg     <= ST_OK;
            size_acc_reg  <= '0;
            flag_bits_reg <= '0;
            flag_pos_reg  <= '0;
            ref_first_reg <= '0;
            out_count_reg <= '0;
            src_reg       <= '0;
            cnt_reg       <= '0;
            last_in_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            error_reg     <= error_next;
            size_acc_reg  <= size_acc_next;
            flag_bits_reg <= flag_bits_next;
            flag_pos_reg  <= flag_pos_next;
            ref_first_reg <= ref_first_next;
            out_count_reg <= out_count_next;
            src_reg       <= src_next;
            cnt_reg       <= cnt_next;
            last_in_reg   <= last_in_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_in_reg <= byte_in_next;
        if (load)
        begin
            kind_reg   <= ld_kind;
            index_reg  <= ld_index;
            obyte_reg  <= ld_byte;
            status_reg <= ld_status;
            olast_reg  <= ld_last;
        end
    end

    // History buffer
    lz10_ram #(
        .WIDTH (8),
        .DEPTH (OUT_SIZE)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (src_reg),
        .rdata (mem_rdata)
    );

    assign in_ready  = (seq_reg == SQ_IN);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_index = index_reg;
    assign out_byte  = obyte_reg;
    assign status    = status_reg;
    assign out_last  = olast_reg;

    // The produced byte count never passes the block size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= CW'(OUT_SIZE))
        else $error("output count beyond block size");

    // A copy write always follows a history read
    a_rd_before_wr: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SQ_WR |-> $past(seq_reg) == SQ_RD || $past(seq_reg) == SQ_WR)
        else $error("copy write without preceding read");

    // A copy read only happens with bytes left to copy
    a_copy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SQ_RD |-> cnt_reg != 5'd0)
        else $error("copy read with empty count");

    // A history write never lands past the block
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> out_count_reg < CW'(OUT_SIZE))
        else $error("history write beyond block");

endmodule

// ----- design/lz10_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module lz10_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: hold the last data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- verif/lz10_block_decompressor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lz10_block_decompressor: streams LZ10 payloads,
// predicts every decoded word in step with the input and compares the output.
// Depends on lz10_pkg and the design sources of lz10_block_decompressor.

module lz10_block_decompressor_tb;
    import lz10_pkg::*;

    localparam int BLOCK         = LZ10_OUT_SIZE;
    localparam int RANDOM_WORDS  = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;

    typedef enum int {
        SK_GOOD,
        SK_BAD_TYPE,
        SK_BAD_SIZE,
        SK_BAD_REF,
        SK_OVERRUN,
        SK_TRUNC,
        SK_NOISE
    } stream_kind_e;

    typedef struct packed {
        logic                  kind;
        logic [LZ10_IDX_W-1:0] idx;
        logic [7:0]            data;
        logic [2:0]            st;
        logic                  last;
    } out_word_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [7:0]            in_byte   = 8'h00;
    logic                  in_last   = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  kind;
    logic [LZ10_IDX_W-1:0] out_index;
    logic [7:0]            out_byte;
    logic [2:0]            status;
    logic                  out_last;

    // Decoder copy: parse state and history of the current block
    phase_t      ph        = PH_TYPE;
    logic [23:0] size_acc  = '0;
    logic [7:0]  flag_bits = '0;
    logic [3:0]  flag_pos  = '0;
    logic [7:0]  ref_first = '0;
    int          out_count = 0;
    status_t     err       = ST_OK;
    logic [7:0]  history [BLOCK];

    out_word_t   decoded_q [$];
    out_word_t   want_w;
    logic [7:0]  stream_q [$];

    int          err_cnt    = 0;
    int          sent_words = 0;
    int          cycle_cnt  = 0;
    bit          quiet      = 1'b0;
    bit          hold_req   = 1'b0;

    lz10_block_decompressor #(
        .OUT_SIZE (BLOCK)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_index (out_index),
        .out_byte  (out_byte),
        .status    (status),
        .out_last  (out_last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("lz10_block_decompressor: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT)
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic push_word(input logic k, input logic [LZ10_IDX_W-1:0] idx,
                             input logic [7:0] d, input logic [2:0] s, input logic lst);
        out_word_t w;
        w.kind = k;
        w.idx  = idx;
        w.data = d;
        w.st   = s;
        w.last = lst;
        decoded_q.push_back(w);
    endtask

    // Store one decoded byte in history and queue its data word
    task automatic put_data(input logic [7:0] d);
        if (out_count < BLOCK)
        begin
            history[out_count] = d;
            push_word(KIND_DATA, LZ10_IDX_W'(out_count), d, ST_OK, 1'b0);
            out_count++;
        end
    endtask

    task automatic fail_with(input status_t code);
        err = code;
        ph  = PH_DRAIN;
    endtask

    // Consume one flag bit after an item and pick the next parse phase
    task automatic advance_flag();
        flag_bits = flag_bits << 1;
        if (flag_pos > 0)
            flag_pos--;
        if (out_count >= BLOCK)
            ph = PH_DRAIN;
        else if (flag_pos == 0)
            ph = PH_FLAG;
        else
            ph = PH_ITEM;
    endtask

    // Work out the words that one accepted input word produces
    task automatic decode_word(input logic [7:0] b, input logic l);
        int      len;
        int      distance;
        int      src;
        status_t st;
        case (ph)
            PH_TYPE:
                if (b != LZ10_TYPE)
                    fail_with(ST_BAD_TYPE);
                else
                    ph = PH_SIZE0;
            PH_SIZE0:
            begin
                size_acc = {16'd0, b};
                ph = PH_SIZE1;
            end
            PH_SIZE1:
            begin
                size_acc[15:8] = b;
                ph = PH_SIZE2;
            end
            PH_SIZE2:
            begin
                size_acc[23:16] = b;
                if (size_acc != 24'(BLOCK))
                    fail_with(ST_BAD_SIZE);
                else
                    ph = PH_FLAG;
            end
            PH_FLAG:
            begin
                flag_bits = b;
                flag_pos  = 4'd8;
                ph = PH_ITEM;
            end
            PH_ITEM:
                if (flag_bits[7])
                begin
                    ref_first = b;
                    ph = PH_REF2;
                end
                else
                begin
                    put_data(b);
                    advance_flag();
                end
            PH_REF2:
            begin
                len      = int'(ref_first[7:4]) + int'(LZ10_LEN_BIAS);
                distance = int'({ref_first[3:0], b}) + 1;
                if (distance > out_count)
                    fail_with(ST_BAD_REF);
                else if (out_count + len > BLOCK)
                    fail_with(ST_OVERRUN);
                else
                begin
                    // copy byte by byte so that overlapping copies repeat
                    for (int i = 0; i < len; i++)
                    begin
                        src = (out_count - distance) % BLOCK;
                        put_data(history[src]);
                    end
                    advance_flag();
                end
            end
            default: ;
        endcase

        // Close the payload with its status word
        if (l)
        begin
            st = err;
            if (st == ST_OK && !(ph == PH_DRAIN && out_count >= BLOCK))
                st = ST_TRUNC;
            push_word(KIND_STATUS, '0, 8'h00, st, 1'b1);
            ph        = PH_TYPE;
            size_acc  = '0;
            flag_bits = '0;
            flag_pos  = '0;
            ref_first = '0;
            out_count = 0;
            err       = ST_OK;
        end
    endtask

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        do
            @(posedge clk);
        while (!in_ready);
        decode_word(b, l);
        sent_words++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_word(stream_q[i], i == stream_q.size() - 1);
    endtask

    // Drop valid and wait for every predicted word to arrive
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // Build one payload of the given kind into stream_q
    task automatic build_stream(input stream_kind_e sk);
        int          produced;
        int          len;
        int          distance;
        int          lim;
        int          inject_at;
        int          n_extra;
        int          cut;
        logic [23:0] size_val;
        logic [7:0]  flags;
        logic [7:0]  grp [$];
        logic [7:0]  b0;
        bit          injected;
        bit          faulty;

        stream_q.delete();
        if (sk == SK_NOISE)
        begin
            n_extra = $urandom_range(1, 6);
            repeat (n_extra) stream_q.push_back(8'($urandom));
            return;
        end

        // Header: type byte and little-endian size
        b0 = 8'($urandom);
        if (b0 == LZ10_TYPE)
            b0 = ~b0;
        stream_q.push_back(sk == SK_BAD_TYPE ? b0 : LZ10_TYPE);
        size_val = 24'(BLOCK);
        if (sk == SK_BAD_SIZE)
        begin
            case ($urandom_range(0, 3))
                0:       size_val = 24'(BLOCK - 1);
                1:       size_val = 24'(BLOCK + 1);
                2:       size_val = 24'(BLOCK) ^ (24'd1 << $urandom_range(8, 23));
                default: size_val = 24'($urandom);
            endcase
            if (size_val == 24'(BLOCK))
                size_val[0] = ~size_val[0];
        end
        stream_q.push_back(size_val[7:0]);
        stream_q.push_back(size_val[15:8]);
        stream_q.push_back(size_val[23:16]);
        if (sk == SK_BAD_TYPE || sk == SK_BAD_SIZE)
        begin
            n_extra = $urandom_range(0, 6);
            repeat (n_extra) stream_q.push_back(8'($urandom));
            return;
        end

        // Body: flag groups of literals and references
        faulty    = (sk == SK_BAD_REF || sk == SK_OVERRUN);
        inject_at = (sk == SK_OVERRUN) ? $urandom_range(BLOCK - 17, BLOCK - 1)
                                       : $urandom_range(0, BLOCK - 1);
        produced  = 0;
        injected  = 1'b0;
        while (produced < BLOCK && !injected)
        begin
            grp.delete();
            flags = '0;
            for (int k = 7; k >= 0; k--)
            begin
                lim = (BLOCK - produced < 18) ? BLOCK - produced : 18;
                if (faulty && inject_at - produced < lim)
                    lim = inject_at - produced;
                if (produced >= BLOCK || injected)
                    flags[k] = 1'($urandom);
                else if (faulty && produced >= inject_at)
                begin
                    flags[k] = 1'b1;
                    injected = 1'b1;
                    if (sk == SK_BAD_REF)
                    begin
                        distance = $urandom_range(produced + 1, 4096);
                        len      = $urandom_range(3, 18);
                    end
                    else
                    begin
                        distance = $urandom_range(1, produced);
                        len      = $urandom_range(BLOCK - produced + 1, 18);
                    end
                    grp.push_back(8'(((len - 3) << 4) | ((distance - 1) >> 8)));
                    grp.push_back(8'(distance - 1));
                end
                else if (produced >= 1 && lim >= 3 && $urandom_range(0, 9) < 6)
                begin
                    len      = $urandom_range(3, lim);
                    distance = $urandom_range(1, produced);
                    flags[k] = 1'b1;
                    grp.push_back(8'(((len - 3) << 4) | ((distance - 1) >> 8)));
                    grp.push_back(8'(distance - 1));
                    produced += len;
                end
                else
                begin
                    flags[k] = 1'b0;
                    grp.push_back(8'($urandom));
                    produced++;
                end
            end
            stream_q.push_back(flags);
            foreach (grp[j])
                stream_q.push_back(grp[j]);
        end

        // Cut short before the block completes
        if (sk == SK_TRUNC)
        begin
            cut = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > cut)
                void'(stream_q.pop_back());
            return;
        end
        n_extra = $urandom_range(0, 3);
        repeat (n_extra) stream_q.push_back(8'($urandom));
    endtask

    // Receiver: random stall before each word, long hold on request
    initial
    begin : rx_side
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare each accepted word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
                report_mismatch("unexpected word, kind", kind, 0);
            else
            begin
                want_w = decoded_q.pop_front();
                if (kind !== want_w.kind)
                    report_mismatch("kind", kind, want_w.kind);
                if (out_index !== want_w.idx)
                    report_mismatch("out_index", out_index, want_w.idx);
                if (out_byte !== want_w.data)
                    report_mismatch("out_byte", out_byte, want_w.data);
                if (status !== want_w.st)
                    report_mismatch("status", status, want_w.st);
                if (out_last !== want_w.last)
                    report_mismatch("out_last", out_last, want_w.last);
            end
        end
    end

    // Bad type, bad size and an end inside the header
    task automatic test_header_errors();
        stream_q = '{8'hEF};
        send_stream();
        stream_q = '{LZ10_TYPE, 8'h80, 8'h00, 8'h01};
        send_stream();
        stream_q = '{LZ10_TYPE};
        send_stream();
    endtask

    // Reference to the farthest distance before any byte exists
    task automatic test_bad_reference();
        stream_q = '{LZ10_TYPE, 8'h80, 8'h00, 8'h00, 8'h80, 8'h0F, 8'hFF};
        send_stream();
    endtask

    // Full block: extreme literals, longest copies, unused flag bits
    task automatic test_full_block();
        stream_q = '{LZ10_TYPE, 8'h80, 8'h00, 8'h00, 8'h3F, 8'hFF, 8'h00};
        repeat (6)
        begin
            stream_q.push_back(8'hF0);
            stream_q.push_back(8'h01);
        end
        stream_q.push_back(8'hFF);
        stream_q.push_back(8'hF0);
        stream_q.push_back(8'h01);
        send_stream();
    endtask

    // Hold the receiver off while the sender keeps offering words
    task automatic test_backpressure();
        quiet = 1'b0;
        hold_req = 1'b1;
        build_stream(SK_GOOD);
        send_stream();
    endtask

    // Pause the sender until all predicted words are out
    task automatic test_drain_pause();
        build_stream(SK_GOOD);
        send_stream();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        build_stream(SK_TRUNC);
        send_stream();
    endtask

    // Mostly well-formed payloads with random content, the rest broken
    task automatic test_random_streams();
        int           stop_at;
        int           n;
        int           r;
        stream_kind_e sk;
        stop_at = sent_words + RANDOM_WORDS;
        n = 0;
        // Run every payload kind once, then random kinds up to the word budget
        while (sent_words < stop_at || n <= int'(SK_NOISE))
        begin
            if (n <= int'(SK_NOISE))
                sk = stream_kind_e'(n);
            else
            begin
                r = $urandom_range(0, 19);
                if (r < 11)       sk = SK_GOOD;
                else if (r == 11) sk = SK_BAD_TYPE;
                else if (r == 12) sk = SK_BAD_SIZE;
                else if (r < 15)  sk = SK_BAD_REF;
                else if (r < 17)  sk = SK_OVERRUN;
                else if (r < 19)  sk = SK_TRUNC;
                else              sk = SK_NOISE;
            end
            quiet = ($urandom_range(0, 3) == 0);
            build_stream(sk);
            send_stream();
            n++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_errors();
        test_bad_reference();
        test_full_block();
        test_backpressure();
        test_drain_pause();
        test_random_streams();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("lz10_block_decompressor: match");
        else
            $display("lz10_block_decompressor: mismatch");
        $finish;
    end

endmodule
